// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL of the heap block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define IMH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define IMH_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/imh_pkg.sv -----
// Types and constants of the indexed min-heap block.
package imh_pkg;

	localparam int VERT_W  = 10;
	localparam int KEY_W   = 32;
	localparam int LIMIT_W = 11;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

	// Operation codes of the mode field
	localparam logic [1:0] MODE_PUSH     = 2'd0;
	localparam logic [1:0] MODE_EXTRACT  = 2'd1;
	localparam logic [1:0] MODE_DECREASE = 2'd2;
	localparam logic [1:0] MODE_CONTAINS = 2'd3;

	// One heap slot: vertex and its key
	typedef struct packed {
		logic [VERT_W-1:0] vertex;
		logic [KEY_W-1:0]  key;
	} slot_t;

endpackage

// ----- rtl/core/imh_ram.sv -----
// Simple dual-port RAM: one write port, one registered read port.
module imh_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 42
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/indexed_min_heap_decrease_key.sv -----
// Each word is looked up and checked; push and decrease key then sift the entry up,
// extract moves the last entry to the root and sifts it down; others finish after the check.
// One word in flight at a time; next word taken the cycle after the result is posted.
// Reset: asynchronous, active low; afterwards a clearing pass over all MAX_VERTICES
// position entries marks all vertices absent, with in_ready low meanwhile.
module indexed_min_heap_decrease_key import imh_pkg::*; #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [LIMIT_W-1:0]  cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          mode,
	input  logic [VERT_W-1:0]   vertex,
	input  logic [KEY_W-1:0]    distance,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                status,
	output logic [VERT_W-1:0]   min_vertex,
	output logic [KEY_W-1:0]    min_distance,
	output logic                present,
	output logic [LIMIT_W-1:0]  entry_count,
	output logic                empty_res
);

`include "assert_macros.svh"

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int XW = AW + 2;
	localparam int PW = AW + 1;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_LOOK = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_EXL  = 4'd4;
	localparam logic [3:0] S_UPR  = 4'd5;
	localparam logic [3:0] S_UPC  = 4'd6;
	localparam logic [3:0] S_DKC  = 4'd7;
	localparam logic [3:0] S_DNL  = 4'd8;
	localparam logic [3:0] S_DNR  = 4'd9;
	localparam logic [3:0] S_DNC  = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	logic [3:0]         state_q;
	logic [AW-1:0]      clr_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [CW-1:0]      fill_q;
	logic [1:0]         mode_q;
	logic [VERT_W-1:0]  vert_q;
	logic [KEY_W-1:0]   dist_q;
	slot_t              cur_q;
	slot_t              lch_q;
	logic [AW-1:0]      idx_q;
	logic               res_status_q;
	logic [VERT_W-1:0]  res_mv_q;
	logic [KEY_W-1:0]   res_md_q;
	logic               res_pres_q;
	logic               out_valid_q;
	logic               status_q;
	logic [VERT_W-1:0]  min_vertex_q;
	logic [KEY_W-1:0]   min_distance_q;
	logic               present_q;
	logic [LIMIT_W-1:0] entry_count_q;
	logic               empty_q;

	// RAM ports
	logic          slot_we;
	logic [AW-1:0] slot_waddr;
	slot_t         slot_wdata;
	logic [AW-1:0] slot_raddr;
	slot_t         slot_rd;
	logic          pos_we;
	logic [AW-1:0] pos_waddr;
	logic [PW-1:0] pos_wdata;
	logic [PW-1:0] pos_rd;

	imh_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VERT_W + KEY_W)) u_slot_ram (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.raddr(slot_raddr), .rdata(slot_rd)
	);

	imh_ram #(.DEPTH(MAX_VERTICES), .WIDTH(PW)) u_pos_ram (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.raddr(AW'(vert_q)), .rdata(pos_rd)
	);

	// Capacity and range checks
	logic [CW-1:0] cap;
	logic          vok;
	logic          pos_hit;
	logic [AW-1:0] pos_idx;
	assign cap     = (32'(limit_q) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(limit_q);
	assign vok     = 32'(vert_q) < 32'(cap);
	assign pos_hit = pos_rd[PW-1];
	assign pos_idx = pos_rd[AW-1:0];

	// Tree navigation
	logic [XW-1:0] l_w, r_w, fill_x;
	logic [AW-1:0] par;
	assign l_w    = {1'b0, idx_q, 1'b0} + XW'(1);
	assign r_w    = l_w + XW'(1);
	assign fill_x = XW'(fill_q);
	assign par    = AW'((idx_q - AW'(1)) >> 1);

	// Sift-down child selection; left wins ties
	logic          lk_ok, rk_ok, dn_move;
	logic [KEY_W-1:0] bkey;
	slot_t         bent;
	logic [AW-1:0] bidx;
	assign lk_ok   = (l_w < fill_x) && (lch_q.key < cur_q.key);
	assign bkey    = lk_ok ? lch_q.key : cur_q.key;
	assign rk_ok   = (r_w < fill_x) && (slot_rd.key < bkey);
	assign dn_move = lk_ok || rk_ok;
	assign bent    = rk_ok ? slot_rd : lch_q;
	assign bidx    = rk_ok ? AW'(r_w) : AW'(l_w);

	logic up_move;
	assign up_move = cur_q.key < slot_rd.key;

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	// RAM control
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = idx_q;
		slot_wdata = cur_q;
		slot_raddr = '0;
		pos_we     = 1'b0;
		pos_waddr  = AW'(cur_q.vertex);
		pos_wdata  = {1'b1, idx_q};
		case (state_q)
			S_CLR: begin
				pos_we    = 1'b1;
				pos_waddr = clr_q;
				pos_wdata = '0;
			end
			S_CHK: begin
				if (mode_q == MODE_EXTRACT && fill_q != '0) begin
					slot_raddr = AW'(fill_q - CW'(1));
					pos_we     = 1'b1;
					pos_waddr  = AW'(slot_rd.vertex);
					pos_wdata  = '0;
				end else if (mode_q == MODE_DECREASE) begin
					slot_raddr = pos_idx;
				end
			end
			S_UPR: begin
				if (idx_q == '0) begin
					slot_we = 1'b1;
					pos_we  = 1'b1;
				end else begin
					slot_raddr = par;
				end
			end
			S_UPC: begin
				slot_we = 1'b1;
				pos_we  = 1'b1;
				if (up_move) begin
					slot_wdata = slot_rd;
					pos_waddr  = AW'(slot_rd.vertex);
				end
			end
			S_DNL: slot_raddr = AW'(l_w);
			S_DNR: slot_raddr = AW'(r_w);
			S_DNC: begin
				slot_we = 1'b1;
				pos_we  = 1'b1;
				if (dn_move) begin
					slot_wdata = bent;
					pos_waddr  = AW'(bent.vertex);
				end
			end
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			limit_q     <= LIMIT_RESET;
			fill_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_VERTICES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: state_q <= S_CHK;
				S_CHK: begin
					state_q <= S_DONE;
					case (mode_q)
						MODE_PUSH: begin
							if (vok && fill_q < cap && !pos_hit) begin
								idx_q   <= AW'(fill_q);
								fill_q  <= fill_q + CW'(1);
								state_q <= S_UPR;
							end
						end
						MODE_EXTRACT: begin
							if (fill_q != '0) begin
								fill_q <= fill_q - CW'(1);
								if (fill_q != CW'(1)) begin
									state_q <= S_EXL;
								end
							end
						end
						MODE_DECREASE: begin
							if (vok && pos_hit && 32'(pos_idx) < 32'(fill_q)) begin
								idx_q   <= pos_idx;
								state_q <= S_DKC;
							end
						end
						default: ;
					endcase
				end
				S_EXL: begin
					idx_q   <= '0;
					state_q <= S_DNL;
				end
				S_UPR: begin
					if (idx_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_UPC;
					end
				end
				S_UPC: begin
					if (up_move) begin
						idx_q   <= par;
						state_q <= S_UPR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DKC: begin
					if (dist_q < slot_rd.key) begin
						state_q <= S_UPR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DNL: state_q <= S_DNR;
				S_DNR: state_q <= S_DNC;
				S_DNC: begin
					if (dn_move) begin
						idx_q   <= bidx;
						state_q <= S_DNL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q       <= mode;
				vert_q       <= vertex;
				dist_q       <= distance;
				res_status_q <= 1'b0;
				res_mv_q     <= '0;
				res_md_q     <= '0;
				res_pres_q   <= 1'b0;
			end
			S_CHK: begin
				case (mode_q)
					MODE_PUSH: begin
						res_status_q <= !(vok && fill_q < cap && !pos_hit);
						cur_q        <= '{vertex: vert_q, key: dist_q};
					end
					MODE_EXTRACT: begin
						res_status_q <= (fill_q == '0);
						if (fill_q != '0) begin
							res_mv_q <= slot_rd.vertex;
							res_md_q <= slot_rd.key;
						end
					end
					MODE_DECREASE: begin
						res_status_q <= !vok;
						cur_q        <= '{vertex: vert_q, key: dist_q};
					end
					default: res_pres_q <= vok && pos_hit;
				endcase
			end
			S_EXL: cur_q <= slot_rd;
			S_DNR: lch_q <= slot_rd;
			S_DONE: begin
				if (out_free) begin
					status_q       <= res_status_q;
					min_vertex_q   <= res_mv_q;
					min_distance_q <= res_md_q;
					present_q      <= res_pres_q;
					entry_count_q  <= LIMIT_W'(fill_q);
					empty_q        <= (fill_q == '0);
				end
			end
			default: ;
		endcase
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign min_vertex   = min_vertex_q;
	assign min_distance = min_distance_q;
	assign present      = present_q;
	assign entry_count  = entry_count_q;
	assign empty_res    = empty_q;

	// Checks
	`IMH_ASSERT(a_fill_bound, 32'(fill_q) <= 32'(MAX_VERTICES), "heap fill above storage")
	`IMH_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready, "second word taken early")
	`IMH_ASSERT(a_empty_flag, out_valid |-> (empty_res == (entry_count == '0)), "empty flag mismatch")
	`IMH_ASSERT_ALWAYS(a_reset_clear, !arst_n |-> !out_valid_q, "result valid in reset")

endmodule

// ----- bench/tb_indexed_min_heap_decrease_key.sv -----
// Testbench for the indexed min-heap: random driver/monitor with a heap predictor.
module tb_indexed_min_heap_decrease_key;
	import imh_pkg::*;

	localparam int NVERT = 1024;

	typedef struct packed {
		logic [1:0]        mode;
		logic [VERT_W-1:0] vertex;
		logic [KEY_W-1:0]  distance;
	} op_t;

	typedef struct packed {
		logic               status;
		logic [VERT_W-1:0]  min_vertex;
		logic [KEY_W-1:0]   min_distance;
		logic               present;
		logic [LIMIT_W-1:0] entry_count;
		logic               empty_res;
	} res_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [LIMIT_W-1:0] cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         mode;
	logic [VERT_W-1:0]  vertex;
	logic [KEY_W-1:0]   distance;
	logic               out_valid;
	logic               out_ready;
	logic               status;
	logic [VERT_W-1:0]  min_vertex;
	logic [KEY_W-1:0]   min_distance;
	logic               present;
	logic [LIMIT_W-1:0] entry_count;
	logic               empty_res;

	indexed_min_heap_decrease_key uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .vertex(vertex),
		.distance(distance), .out_valid(out_valid), .out_ready(out_ready),
		.status(status), .min_vertex(min_vertex), .min_distance(min_distance),
		.present(present), .entry_count(entry_count), .empty_res(empty_res)
	);

	// Predicted heap state
	logic [VERT_W-1:0] heap_vert [NVERT];
	logic [KEY_W-1:0]  heap_key  [NVERT];
	int                vert_slot [NVERT];
	bit                vert_in   [NVERT];
	int                heap_fill;
	int                vert_limit;

	op_t  op_q[$];
	res_t want_q[$];
	int   errors;
	int   words_in;
	int   words_out;
	int   mode_cnt [4];
	bit   send_steady;
	bit   recv_steady;

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, words_out);
	endtask

	function automatic void swap_slots(int a, int b);
		logic [VERT_W-1:0] tv;
		logic [KEY_W-1:0]  tk;
		tv = heap_vert[a];
		tk = heap_key[a];
		heap_vert[a] = heap_vert[b];
		heap_key[a] = heap_key[b];
		heap_vert[b] = tv;
		heap_key[b] = tk;
		vert_slot[heap_vert[a]] = a;
		vert_slot[heap_vert[b]] = b;
	endfunction

	function automatic void sift_up(int i);
		int up;
		while (i > 0) begin
			up = (i - 1) / 2;
			if (!(heap_key[i] < heap_key[up]))
				break;
			swap_slots(i, up);
			i = up;
		end
	endfunction

	// Apply one operation to the predicted heap and return its result word
	function automatic res_t heap_apply(op_t op);
		res_t r;
		int   cap, i, best, l;
		bit   vok;
		r = '0;
		cap = vert_limit > NVERT ? NVERT : vert_limit;
		vok = op.vertex < cap;
		case (op.mode)
			MODE_PUSH: begin
				if (!vok || heap_fill >= cap || vert_in[op.vertex]) begin
					r.status = 1'b1;
				end else begin
					i = heap_fill;
					heap_vert[i] = op.vertex;
					heap_key[i] = op.distance;
					vert_slot[op.vertex] = i;
					vert_in[op.vertex] = 1'b1;
					heap_fill++;
					sift_up(i);
				end
			end
			MODE_EXTRACT: begin
				if (heap_fill == 0) begin
					r.status = 1'b1;
				end else begin
					r.min_vertex = heap_vert[0];
					r.min_distance = heap_key[0];
					vert_in[heap_vert[0]] = 1'b0;
					heap_fill--;
					if (heap_fill > 0) begin
						heap_vert[0] = heap_vert[heap_fill];
						heap_key[0] = heap_key[heap_fill];
						vert_slot[heap_vert[0]] = 0;
						// sift down, left child wins ties
						i = 0;
						forever begin
							best = i;
							l = 2 * i + 1;
							if (l < heap_fill && heap_key[l] < heap_key[best])
								best = l;
							if (l + 1 < heap_fill && heap_key[l + 1] < heap_key[best])
								best = l + 1;
							if (best == i)
								break;
							swap_slots(i, best);
							i = best;
						end
					end
				end
			end
			MODE_DECREASE: begin
				if (!vok) begin
					r.status = 1'b1;
				end else if (vert_in[op.vertex]) begin
					i = vert_slot[op.vertex];
					if (i < heap_fill && op.distance < heap_key[i]) begin
						heap_key[i] = op.distance;
						sift_up(i);
					end
				end
			end
			default: r.present = vok && vert_in[op.vertex];
		endcase
		r.entry_count = LIMIT_W'(heap_fill);
		r.empty_res = heap_fill == 0;
		return r;
	endfunction

	// Random operation, biased toward vertices in range and tied keys
	function automatic op_t rand_op(int cap);
		op_t op;
		int  r, top;
		r = $urandom_range(0, 99);
		op.mode = r < 40 ? MODE_PUSH : r < 65 ? MODE_EXTRACT : r < 88 ? MODE_DECREASE
			: MODE_CONTAINS;
		top = cap + 1 > NVERT - 1 ? NVERT - 1 : cap + 1;
		op.vertex = $urandom_range(0, 99) < 85 ? VERT_W'($urandom_range(0, top))
			: VERT_W'($urandom);
		r = $urandom_range(0, 9);
		op.distance = r == 0 ? '0 : r == 1 ? '1 : r < 6 ? $urandom_range(0, 15) : $urandom;
		return op;
	endfunction

	function automatic op_t mk(logic [1:0] m, int v, logic [KEY_W-1:0] d);
		op_t op;
		op.mode = m;
		op.vertex = VERT_W'(v);
		op.distance = d;
		return op;
	endfunction

	// Clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Driver: presents queued words with random gaps
	always @(posedge clk or negedge arst_n) begin
		int  gap;
		op_t cur;
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= '0;
			vertex <= '0;
			distance <= '0;
			gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				cur = {mode, vertex, distance};
				want_q.push_back(heap_apply(cur));
				mode_cnt[cur.mode]++;
				words_in++;
				gap = send_steady ? 0 : $urandom_range(0, 10);
			end
			if (in_valid && !in_ready) begin
				// hold the word until taken
			end else if (gap > 0) begin
				gap--;
				in_valid <= 1'b0;
			end else if (op_q.size() > 0) begin
				cur = op_q.pop_front();
				mode <= cur.mode;
				vertex <= cur.vertex;
				distance <= cur.distance;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks result words and stalls at random
	always @(posedge clk or negedge arst_n) begin
		int   stall;
		res_t got, want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				words_out++;
				got = {status, min_vertex, min_distance, present, entry_count, empty_res};
				if (want_q.size() == 0) begin
					report_mismatch("unexpected word", 1, 0);
				end else begin
					want = want_q.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
					if (got.min_vertex !== want.min_vertex)
						report_mismatch("min_vertex", got.min_vertex, want.min_vertex);
					if (got.min_distance !== want.min_distance)
						report_mismatch("min_distance", got.min_distance, want.min_distance);
					if (got.present !== want.present)
						report_mismatch("present", got.present, want.present);
					if (got.entry_count !== want.entry_count)
						report_mismatch("entry_count", got.entry_count, want.entry_count);
					if (got.empty_res !== want.empty_res)
						report_mismatch("empty_res", got.empty_res, want.empty_res);
				end
				stall = recv_steady ? 0 : $urandom_range(0, 10);
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Wait until every word is sent and every result is back, then settle
	task automatic drain();
		while (op_q.size() > 0 || in_valid || want_q.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_limit(int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= LIMIT_W'(value);
		vert_limit = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random phases: limit and word count
	int phase_limit [9] = '{16, 1024, 1, 8, 2047, 64, 3, 0, 1024};
	int phase_words [9] = '{300, 300, 80, 250, 200, 250, 100, 20, 150};

	initial begin
		int cap;
		errors = 0;
		words_in = 0;
		words_out = 0;
		mode_cnt = '{0, 0, 0, 0};
		send_steady = 1'b0;
		recv_steady = 1'b0;
		heap_fill = 0;
		vert_limit = LIMIT_RESET;
		for (int i = 0; i < NVERT; i++)
			vert_in[i] = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// clearing pass after reset
		while (!in_ready)
			@(posedge clk);

		// Directed: empty extract, extreme keys and vertices, duplicates, ties
		op_q.push_back(mk(MODE_EXTRACT, 0, 0));
		op_q.push_back(mk(MODE_CONTAINS, 0, 0));
		op_q.push_back(mk(MODE_PUSH, 0, '1));
		op_q.push_back(mk(MODE_PUSH, 1023, '0));
		op_q.push_back(mk(MODE_PUSH, 0, 3));
		op_q.push_back(mk(MODE_DECREASE, 0, 5));
		op_q.push_back(mk(MODE_DECREASE, 0, 7));
		op_q.push_back(mk(MODE_DECREASE, 5, 1));
		op_q.push_back(mk(MODE_CONTAINS, 1023, 0));
		op_q.push_back(mk(MODE_CONTAINS, 5, 0));
		op_q.push_back(mk(MODE_PUSH, 2, 5));
		op_q.push_back(mk(MODE_PUSH, 3, 5));
		for (int i = 0; i < 5; i++)
			op_q.push_back(mk(MODE_EXTRACT, 0, 0));
		drain();

		// Small limit: bad vertices, full heap, then limit lowered while filled
		set_limit(4);
		op_q.push_back(mk(MODE_PUSH, 4, 1));
		op_q.push_back(mk(MODE_DECREASE, 7, 1));
		op_q.push_back(mk(MODE_CONTAINS, 9, 0));
		for (int i = 0; i < 4; i++)
			op_q.push_back(mk(MODE_PUSH, 3 - i, 10 - i));
		op_q.push_back(mk(MODE_PUSH, 3, 1));
		drain();
		set_limit(2);
		op_q.push_back(mk(MODE_PUSH, 0, 1));
		for (int i = 0; i < 5; i++)
			op_q.push_back(mk(MODE_EXTRACT, 0, 0));
		drain();

		// Random phases over several limits, the extremes among them
		for (int p = 0; p < 9; p++) begin
			set_limit(phase_limit[p]);
			cap = phase_limit[p] > NVERT ? NVERT : phase_limit[p];
			send_steady = p % 3 == 1;
			recv_steady = p % 4 == 2;
			for (int n = 0; n < phase_words[p]; n++)
				op_q.push_back(rand_op(cap));
			drain();
		end

		$display("Checked %0d result words for %0d operations", words_out, words_in);
		$display("Mix: %0d push, %0d extract, %0d decrease, %0d contains; limits 0 to 2047",
			mode_cnt[0], mode_cnt[1], mode_cnt[2], mode_cnt[3]);
		if (errors == 0 && want_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog
	initial begin
		#(20 * 800000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- indexed_min_heap_decrease_key.f -----
+incdir+rtl/core
rtl/core/imh_pkg.sv
rtl/core/imh_ram.sv
rtl/core/indexed_min_heap_decrease_key.sv
bench/tb_indexed_min_heap_decrease_key.sv
